[rtl/jsu_pkg.sv]
package jsu_pkg;

    // result status codes
    localparam logic [1:0] ST_DATA       = 2'd0;
    localparam logic [1:0] ST_END        = 2'd1;
    localparam logic [1:0] ST_NOT_STRING = 2'd2;

    // utf-8 length boundaries
    localparam logic [20:0] UTF8_TWO_BYTE   = 21'h00080;
    localparam logic [20:0] UTF8_THREE_BYTE = 21'h00800;
    localparam logic [20:0] UTF8_FOUR_BYTE  = 21'h10000;

    // default depth of the group queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // all result bytes caused by one input item
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic [1:0]      status;
    } grp_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic valid;
        grp_t grp;
    } head_t;

    // code point to utf-8 group
    function automatic grp_t utf8_grp(logic [20:0] cp);
        grp_t g;
        g = '0;
        g.status = ST_DATA;
        if (cp < UTF8_TWO_BYTE)
        begin
            g.bytes[0] = cp[7:0];
            g.last_idx = 2'd0;
        end
        else if (cp < UTF8_THREE_BYTE)
        begin
            g.bytes[0] = {3'b110, cp[10:6]};
            g.bytes[1] = {2'b10, cp[5:0]};
            g.last_idx = 2'd1;
        end
        else if (cp < UTF8_FOUR_BYTE)
        begin
            g.bytes[0] = {4'b1110, cp[15:12]};
            g.bytes[1] = {2'b10, cp[11:6]};
            g.bytes[2] = {2'b10, cp[5:0]};
            g.last_idx = 2'd2;
        end
        else
        begin
            g.bytes[0] = {5'b11110, cp[20:18]};
            g.bytes[1] = {2'b10, cp[17:12]};
            g.bytes[2] = {2'b10, cp[11:6]};
            g.bytes[3] = {2'b10, cp[5:0]};
            g.last_idx = 2'd3;
        end
        return g;
    endfunction

    // single byte group with a status
    function automatic grp_t single_grp(logic [7:0] b, logic [1:0] st);
        grp_t g;
        g = '0;
        g.bytes[0] = b;
        g.last_idx = 2'd0;
        g.status = st;
        return g;
    endfunction

endpackage

[rtl/json_string_unescape.sv]
// result groups are pushed into the group queue and offered from its head
// throughput: one input item per cycle while the group queue has room
// output side delivers one byte per cycle while out_ready is high; a code point
// yields up to four bytes, so long multibyte runs are set by byte rate and queue depth
// reset: asynchronous active low rst_n; decoder waits for an opening quote, queue empty
module json_string_unescape
#(
    parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic [1:0] status,
    output logic       last_of_run
);

    logic            in_fire;
    logic            push;
    logic            pop;
    logic            full;
    jsu_pkg::grp_t   push_grp;
    jsu_pkg::head_t  head;

    assign in_ready = !full;
    assign in_fire = in_valid & in_ready;

    // parser
    jsu_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_byte  (in_byte),
        .push     (push),
        .push_grp (push_grp)
    );

    // group queue
    jsu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_grp (push_grp),
        .pop      (pop),
        .full     (full),
        .head     (head)
    );

    // output serializer
    jsu_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .status      (status),
        .last_of_run (last_of_run)
    );

endmodule

[rtl/jsu_front.sv]
module jsu_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic [7:0]        in_byte,
    output logic              push,
    output jsu_pkg::grp_t     push_grp
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BODY,
        PH_ESC,
        PH_HEXHI,
        PH_WANTBS,
        PH_WANTU,
        PH_HEXLO
    } ph_t;

    typedef struct packed {
        ph_t           ph;
        logic          push;
        jsu_pkg::grp_t grp;
        logic          start_hex;
    } step_t;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    ph_t         ph_reg, ph_next;
    logic [15:0] acc_reg, acc_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        bad_reg, bad_next;
    logic [9:0]  hh_reg, hh_next;
    logic        push_next;
    jsu_pkg::grp_t grp_next;

    logic [3:0]  digit;
    logic        digit_bad;
    logic [15:0] acc_shift;
    logic        bad_shift;
    logic [15:0] hex_val;
    logic        val_low, val_high;
    step_t       st;

    // ordinary string text
    function automatic step_t body_step(logic [7:0] c);
        step_t s;
        s = '0;
        s.ph = PH_BODY;
        if (c == CH_QUOTE || c == CH_NUL)
        begin
            s.push = 1'b1;
            s.grp = jsu_pkg::single_grp(8'h00, jsu_pkg::ST_END);
            s.ph = PH_IDLE;
        end
        else if (c == CH_BSLASH)
        begin
            s.ph = PH_ESC;
        end
        else
        begin
            s.push = 1'b1;
            s.grp = jsu_pkg::single_grp(c, jsu_pkg::ST_DATA);
        end
        return s;
    endfunction

    // character after a backslash
    function automatic step_t esc_step(logic [7:0] c);
        step_t s;
        s = '0;
        s.ph = PH_BODY;
        s.push = 1'b1;
        case (c)
            CH_B:    s.grp = jsu_pkg::single_grp(8'h08, jsu_pkg::ST_DATA);
            CH_F:    s.grp = jsu_pkg::single_grp(8'h0C, jsu_pkg::ST_DATA);
            CH_N:    s.grp = jsu_pkg::single_grp(8'h0A, jsu_pkg::ST_DATA);
            CH_R:    s.grp = jsu_pkg::single_grp(8'h0D, jsu_pkg::ST_DATA);
            CH_T:    s.grp = jsu_pkg::single_grp(8'h09, jsu_pkg::ST_DATA);
            CH_U:
            begin
                s.push = 1'b0;
                s.start_hex = 1'b1;
                s.ph = PH_HEXHI;
            end
            CH_NUL:
            begin
                s.grp = jsu_pkg::single_grp(8'h00, jsu_pkg::ST_END);
                s.ph = PH_IDLE;
            end
            default: s.grp = jsu_pkg::single_grp(c, jsu_pkg::ST_DATA);
        endcase
        return s;
    endfunction

    // hex digit decode
    always_comb
    begin
        digit = 4'd0;
        digit_bad = 1'b0;
        if (in_byte >= 8'h30 && in_byte <= 8'h39)
            digit = in_byte[3:0];
        else if ((in_byte >= 8'h41 && in_byte <= 8'h46) ||
                 (in_byte >= 8'h61 && in_byte <= 8'h66))
            digit = in_byte[3:0] + 4'd9;
        else
            digit_bad = 1'b1;
        acc_shift = {acc_reg[11:0], digit};
        bad_shift = bad_reg | digit_bad;
        hex_val = bad_shift ? 16'h0000 : acc_shift;
        val_high = (hex_val[15:10] == 6'b110110);
        val_low = (hex_val[15:10] == 6'b110111);
    end

    // phase decoder
    always_comb
    begin
        st = '0;
        st.ph = ph_reg;
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        bad_next = bad_reg;
        hh_next = hh_reg;
        unique case (ph_reg)
            PH_BODY: st = body_step(in_byte);
            PH_ESC:  st = esc_step(in_byte);
            PH_HEXHI:
            begin
                acc_next = acc_shift;
                bad_next = bad_shift;
                if (cnt_reg == 2'd3)
                begin
                    st.ph = PH_BODY;
                    if (hex_val == 16'h0000 || val_low)
                        st.push = 1'b0;
                    else if (val_high)
                    begin
                        hh_next = hex_val[9:0];
                        st.ph = PH_WANTBS;
                    end
                    else
                    begin
                        st.push = 1'b1;
                        st.grp = jsu_pkg::utf8_grp({5'd0, hex_val});
                    end
                end
                else
                    cnt_next = cnt_reg + 2'd1;
            end
            PH_WANTBS:
            begin
                if (in_byte == CH_BSLASH)
                    st.ph = PH_WANTU;
                else
                begin
                    hh_next = 10'd0;
                    st = body_step(in_byte);
                end
            end
            PH_WANTU:
            begin
                if (in_byte == CH_U)
                begin
                    st.start_hex = 1'b1;
                    st.ph = PH_HEXLO;
                end
                else
                begin
                    hh_next = 10'd0;
                    st = esc_step(in_byte);
                end
            end
            PH_HEXLO:
            begin
                acc_next = acc_shift;
                bad_next = bad_shift;
                if (cnt_reg == 2'd3)
                begin
                    st.ph = PH_BODY;
                    hh_next = 10'd0;
                    if (val_low)
                    begin
                        st.push = 1'b1;
                        st.grp = jsu_pkg::utf8_grp(jsu_pkg::UTF8_FOUR_BYTE +
                                                   {1'b0, hh_reg, hex_val[9:0]});
                    end
                end
                else
                    cnt_next = cnt_reg + 2'd1;
            end
            default:
            begin
                if (in_byte == CH_QUOTE)
                    st.ph = PH_BODY;
                else
                begin
                    st.push = 1'b1;
                    st.grp = jsu_pkg::single_grp(8'h00, jsu_pkg::ST_NOT_STRING);
                    st.ph = PH_IDLE;
                end
            end
        endcase
        if (st.start_hex)
        begin
            acc_next = 16'h0000;
            cnt_next = 2'd0;
            bad_next = 1'b0;
        end
        ph_next = st.ph;
        push_next = in_fire & st.push;
        grp_next = st.grp;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg <= PH_IDLE;
            acc_reg <= 16'h0000;
            cnt_reg <= 2'd0;
            bad_reg <= 1'b0;
            hh_reg <= 10'd0;
        end
        else if (in_fire)
        begin
            ph_reg <= ph_next;
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
            bad_reg <= bad_next;
            hh_reg <= hh_next;
        end
    end

    assign push = push_next;
    assign push_grp = grp_next;

endmodule

[rtl/jsu_queue.sv]
module jsu_queue
#(
    parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  jsu_pkg::grp_t     push_grp,
    input  logic              pop,
    output logic              full,
    output jsu_pkg::head_t    head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    jsu_pkg::grp_t mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_pop;

    assign do_pop = pop & (cnt_reg != '0);
    assign full = (cnt_reg == FULL_CNT);
    assign head.valid = (cnt_reg != '0);
    assign head.grp = mem[rd_ptr_reg];

    // group storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_grp;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (!push && do_pop)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // never write into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("push into full queue");

    // fill count rises by one on a push without a pop
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !do_pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("fill count lost a push");

endmodule

[rtl/jsu_back.sv]
module jsu_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  jsu_pkg::head_t    head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic [1:0]        status,
    output logic              last_of_run
);

    logic [1:0] idx_reg, idx_next;
    logic       out_fire;

    // serialize the head group one byte per item
    assign out_valid = head.valid;
    assign out_byte = head.grp.bytes[idx_reg];
    assign status = head.grp.status;
    assign last_of_run = (idx_reg == head.grp.last_idx);
    assign out_fire = out_valid & out_ready;
    assign pop = out_fire & last_of_run;

    always_comb
    begin
        idx_next = idx_reg;
        if (out_fire)
            idx_next = last_of_run ? 2'd0 : idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 2'd0;
        else
            idx_reg <= idx_next;
    end

    // byte index never passes the group's last byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> idx_reg <= head.grp.last_idx)
        else $error("byte index beyond group");

    // status items are single byte groups
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != jsu_pkg::ST_DATA) |-> (idx_reg == 2'd0 && last_of_run))
        else $error("status item not alone in its group");

endmodule
